>>> design/coverage_harmonic_merge_macros.svh
// Assertion helpers for the coverage merge block
`ifndef COVERAGE_HARMONIC_MERGE_MACROS_SVH
`define COVERAGE_HARMONIC_MERGE_MACROS_SVH

`define CHM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define CHM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/chm_pkg.sv
`default_nettype none
package chm_pkg;
   localparam int NUM_LANES = 4;
   localparam int KMER_W = 8;
   localparam logic [KMER_W-1:0] KMER_RESET = 8'd11;
endpackage
`default_nettype wire

>>> design/coverage_harmonic_merge.sv
// Coverage merge of two adjacent graph nodes. One item is accepted per clock, and
// a stalled result holds the whole pipeline. A restoring divider resolves one
// quotient bit per stage in each of the four channel lanes. kmer_size is written
// through csr_wr_en / csr_wr_data; the user must write it only while the pipeline
// is empty, which the block does not enforce. A value of 0 acts as 1.
`default_nettype none
`include "coverage_harmonic_merge_macros.svh"
module coverage_harmonic_merge
   import chm_pkg::*;
#(
   parameter int COUNT_WIDTH = 16,
   parameter int LEN_WIDTH   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [KMER_W-1:0]      csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [LEN_WIDTH-1:0]   req_node_len,
   input  wire logic [LEN_WIDTH-1:0]   req_buddy_len,
   input  wire logic [COUNT_WIDTH-1:0] req_tumor_fwd_a,
   input  wire logic [COUNT_WIDTH-1:0] req_tumor_rev_a,
   input  wire logic [COUNT_WIDTH-1:0] req_normal_fwd_a,
   input  wire logic [COUNT_WIDTH-1:0] req_normal_rev_a,
   input  wire logic [COUNT_WIDTH-1:0] req_tumor_fwd_b,
   input  wire logic [COUNT_WIDTH-1:0] req_tumor_rev_b,
   input  wire logic [COUNT_WIDTH-1:0] req_normal_fwd_b,
   input  wire logic [COUNT_WIDTH-1:0] req_normal_rev_b,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COUNT_WIDTH-1:0]      rsp_merged_tumor_fwd,
   output logic [COUNT_WIDTH-1:0]      rsp_merged_tumor_rev,
   output logic [COUNT_WIDTH-1:0]      rsp_merged_normal_fwd,
   output logic [COUNT_WIDTH-1:0]      rsp_merged_normal_rev,
   output logic                        rsp_length_error
);
   localparam int CW   = COUNT_WIDTH;
   localparam int LW   = LEN_WIDTH;
   localparam int NL   = NUM_LANES;
   localparam int SW   = CW + 1;
   localparam int ABW  = 2 * CW;
   localparam int ABSW = 3 * CW + 1;
   localparam int BSW  = 2 * CW + 1;
   localparam int ABCW = 2 * CW + KMER_W;
   localparam int TW   = LW + 1;
   localparam int NUMW = ABSW + TW;
   localparam int DTW  = BSW + LW;
   localparam int DENW = 2 * CW + LW + 3;
   localparam int D2W  = DENW + 1;
   localparam int WW   = 3 * CW + LW + 4;

   logic [KMER_W-1:0] kmer_ff;
   logic              advance;

   logic [CW-1:0] a_in [NL];
   logic [CW-1:0] b_in [NL];

   logic              v1_ff, err1_ff;
   logic [LW-1:0]     ua1_ff, ub1_ff;
   logic [KMER_W-1:0] c1_ff;
   logic [TW-1:0]     t1_ff;
   logic [CW-1:0]     a1_ff [NL];
   logic [CW-1:0]     b1_ff [NL];
   logic [SW-1:0]     s1_ff [NL];
   logic [ABW-1:0]    ab1_ff [NL];
   logic              z1_ff [NL];

   logic              v2_ff, err2_ff;
   logic [LW-1:0]     ua2_ff, ub2_ff;
   logic [TW-1:0]     t2_ff;
   logic [ABSW-1:0]   abs2_ff [NL];
   logic [BSW-1:0]    bs2_ff [NL];
   logic [BSW-1:0]    as2_ff [NL];
   logic [ABCW-1:0]   abc2_ff [NL];
   logic              z2_ff [NL];

   logic              v3_ff, err3_ff;
   logic [NUMW-1:0]   num3_ff [NL];
   logic [DTW-1:0]    d13_ff [NL];
   logic [DTW-1:0]    d33_ff [NL];
   logic [ABCW-1:0]   abc3_ff [NL];
   logic              z3_ff [NL];

   logic              v4_ff, err4_ff;
   logic [WW-1:0]     n24_ff [NL];
   logic [D2W-1:0]    d24_ff [NL];
   logic              z4_ff [NL];

   logic              dv_ff  [CW+1];
   logic              derr_ff [CW+1];
   logic [WW-1:0]     rem_ff [CW+1][NL];
   logic [D2W-1:0]    dd_ff  [CW+1][NL];
   logic [CW-1:0]     q_ff   [CW+1][NL];
   logic              sat_ff [CW+1][NL];
   logic              dz_ff  [CW+1][NL];

   logic [CW-1:0]     res [NL];

   logic [KMER_W-1:0] k_eff;
   logic [DENW-1:0]   den_sum [NL];

   assign a_in[0] = req_tumor_fwd_a;
   assign a_in[1] = req_tumor_rev_a;
   assign a_in[2] = req_normal_fwd_a;
   assign a_in[3] = req_normal_rev_a;
   assign b_in[0] = req_tumor_fwd_b;
   assign b_in[1] = req_tumor_rev_b;
   assign b_in[2] = req_normal_fwd_b;
   assign b_in[3] = req_normal_rev_b;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign k_eff     = (kmer_ff == '0) ? KMER_W'(1) : kmer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_ff <= KMER_RESET;
      end else if (csr_wr_en) begin
         kmer_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int j = 0; j <= CW; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         dv_ff[0] <= v4_ff;
         for (int j = 0; j < CW; j++) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         den_sum[l] = DENW'(d13_ff[l]) + DENW'(abc3_ff[l]) + DENW'(d33_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err1_ff <= (req_node_len < LW'(k_eff)) || (req_buddy_len < LW'(k_eff));
         ua1_ff  <= req_node_len - LW'(k_eff) + LW'(1);
         ub1_ff  <= req_buddy_len - LW'(k_eff) + LW'(1);
         c1_ff   <= k_eff - KMER_W'(1);
         t1_ff   <= TW'(req_node_len) + TW'(req_buddy_len) - TW'(k_eff) + TW'(1);
         for (int l = 0; l < NL; l++) begin
            a1_ff[l]  <= a_in[l];
            b1_ff[l]  <= b_in[l];
            s1_ff[l]  <= SW'(a_in[l]) + SW'(b_in[l]);
            ab1_ff[l] <= ABW'(a_in[l]) * ABW'(b_in[l]);
            z1_ff[l]  <= (a_in[l] == '0) || (b_in[l] == '0);
         end

         err2_ff <= err1_ff;
         ua2_ff  <= ua1_ff;
         ub2_ff  <= ub1_ff;
         t2_ff   <= t1_ff;
         for (int l = 0; l < NL; l++) begin
            abs2_ff[l] <= ABSW'(ab1_ff[l]) * ABSW'(s1_ff[l]);
            bs2_ff[l]  <= BSW'(b1_ff[l]) * BSW'(s1_ff[l]);
            as2_ff[l]  <= BSW'(a1_ff[l]) * BSW'(s1_ff[l]);
            abc2_ff[l] <= ABCW'(ab1_ff[l]) * ABCW'(c1_ff);
            z2_ff[l]   <= z1_ff[l];
         end

         err3_ff <= err2_ff;
         for (int l = 0; l < NL; l++) begin
            num3_ff[l] <= NUMW'(abs2_ff[l]) * NUMW'(t2_ff);
            d13_ff[l]  <= DTW'(bs2_ff[l]) * DTW'(ua2_ff);
            d33_ff[l]  <= DTW'(as2_ff[l]) * DTW'(ub2_ff);
            abc3_ff[l] <= abc2_ff[l];
            z3_ff[l]   <= z2_ff[l];
         end

         err4_ff <= err3_ff;
         for (int l = 0; l < NL; l++) begin
            n24_ff[l] <= (WW'(num3_ff[l]) << 1) + WW'(den_sum[l]);
            d24_ff[l] <= D2W'(den_sum[l]) << 1;
            z4_ff[l]  <= z3_ff[l] || (den_sum[l] == '0);
         end

         derr_ff[0] <= err4_ff;
         for (int l = 0; l < NL; l++) begin
            rem_ff[0][l] <= n24_ff[l];
            dd_ff[0][l]  <= d24_ff[l];
            q_ff[0][l]   <= '0;
            sat_ff[0][l] <= n24_ff[l] >= (WW'(d24_ff[l]) << CW);
            dz_ff[0][l]  <= z4_ff[l];
         end

         for (int j = 0; j < CW; j++) begin
            derr_ff[j+1] <= derr_ff[j];
            for (int l = 0; l < NL; l++) begin
               dd_ff[j+1][l]  <= dd_ff[j][l];
               sat_ff[j+1][l] <= sat_ff[j][l];
               dz_ff[j+1][l]  <= dz_ff[j][l];
               if (rem_ff[j][l] >= (WW'(dd_ff[j][l]) << (CW - 1 - j))) begin
                  rem_ff[j+1][l] <= rem_ff[j][l] - (WW'(dd_ff[j][l]) << (CW - 1 - j));
                  q_ff[j+1][l]   <= q_ff[j][l] | (CW'(1) << (CW - 1 - j));
               end else begin
                  rem_ff[j+1][l] <= rem_ff[j][l];
                  q_ff[j+1][l]   <= q_ff[j][l];
               end
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         priority if (derr_ff[CW] || dz_ff[CW][l]) begin
            res[l] = '0;
         end else if (sat_ff[CW][l]) begin
            res[l] = '1;
         end else begin
            res[l] = q_ff[CW][l];
         end
      end
   end

   assign rsp_valid             = dv_ff[CW];
   assign rsp_length_error      = derr_ff[CW];
   assign rsp_merged_tumor_fwd  = res[0];
   assign rsp_merged_tumor_rev  = res[1];
   assign rsp_merged_normal_fwd = res[2];
   assign rsp_merged_normal_rev = res[3];

   `CHM_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")
   `CHM_ASSERT(a_err_zero, rsp_valid && rsp_length_error |-> (rsp_merged_tumor_fwd == '0) && (rsp_merged_tumor_rev == '0) && (rsp_merged_normal_fwd == '0) && (rsp_merged_normal_rev == '0), "length error with nonzero counts")
   `CHM_ASSERT(a_enter, req_valid && !req_stall |=> v1_ff, "accepted transfer lost at pipeline entry")
endmodule
`default_nettype wire
